FILE: hw/rtl/cpfm_pkg.sv
// Shared widths, register indexes, reset values and control types of the frequency meter.
`default_nettype none

package cpfm_pkg;

  localparam int CAP_W      = 16;  // capture_value / period_ticks width
  localparam int CLK_W      = 26;  // timer_clock_hz register
  localparam int PRE_W      = 17;  // prescale_divisor register
  localparam int FREQ_W     = 34;  // quotient / frequency_q8 width
  localparam int Q8_SHIFT   = 8;
  localparam int DIV_STEPS  = FREQ_W;  // one quotient bit per step
  localparam int STEP_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CLK_W-1:0] CLOCK_RESET    = 26'd24000000;
  localparam logic [PRE_W-1:0] PRESCALE_RESET = 17'd4096;

  localparam logic [CFG_IDX_W-1:0] REG_CLOCK    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESCALE = 2'd1;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  typedef struct packed {
    logic load_first;   // store first capture
    logic load_second;  // latch period, equal flag, direction
    logic load_prod;    // register period * prescale, seed divider
    logic div_step;     // one restoring division step
    logic load_out;     // fill output register
  } cpfm_cmd_t;

  typedef struct packed {
    logic err;          // captures were equal
  } cpfm_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cpfm_dp.sv
// Datapath: config registers, capture store, period multiplier, serial divider, output register.
`default_nettype none

module cpfm_dp #(
  parameter int COUNTER_WIDTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [cpfm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cpfm_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic [cpfm_pkg::CAP_W-1:0]         capture_value,
  input  wire logic                               direction_level,
  input  wire cpfm_pkg::cpfm_cmd_t                cmd,
  output cpfm_pkg::cpfm_sts_t                     sts,
  output logic [cpfm_pkg::CAP_W-1:0]              period_ticks,
  output logic [cpfm_pkg::FREQ_W-1:0]             frequency_q8,
  output logic                                    capture_error,
  output logic                                    direction_forward
);
  import cpfm_pkg::*;

  localparam int DW    = COUNTER_WIDTH + PRE_W;
  localparam int TW    = FREQ_W + 1;
  localparam int CMP_W = (DW > TW) ? DW : TW;
  localparam logic [CAP_W-1:0] CAP_MASK = (COUNTER_WIDTH >= CAP_W) ? {CAP_W{1'b1}} :
                                          CAP_W'((64'd1 << COUNTER_WIDTH) - 64'd1);

  logic [CLK_W-1:0]         clock_hz;
  logic [PRE_W-1:0]         prescale;
  logic [CAP_W-1:0]         first_cap;
  logic [COUNTER_WIDTH-1:0] period;
  logic                     err;
  logic                     dir;
  logic [DW-1:0]            divisor;
  logic [FREQ_W-1:0]        rem;
  logic [FREQ_W-1:0]        quo;

  logic [CAP_W-1:0]         cap_in;
  logic [PRE_W-1:0]         pre_eff;
  logic [TW-1:0]            trial;
  logic [CMP_W-1:0]         trial_ext;
  logic [CMP_W-1:0]         div_ext;
  logic [CMP_W-1:0]         diff;
  logic                     ge;

  always_comb begin
    cap_in    = capture_value & CAP_MASK;
    pre_eff   = (prescale == '0) ? PRE_W'(1) : prescale;
    trial     = {rem, quo[FREQ_W-1]};
    trial_ext = CMP_W'(trial);
    div_ext   = CMP_W'(divisor);
    ge        = (trial_ext >= div_ext);
    diff      = trial_ext - div_ext;
  end

  assign sts.err = err;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz <= CLOCK_RESET;
      prescale <= PRESCALE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_CLOCK) begin
        clock_hz <= cfg_data[CLK_W-1:0];
      end
      if (cfg_index == REG_PRESCALE) begin
        prescale <= cfg_data[PRE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_first) begin
      first_cap <= cap_in;
    end
    if (cmd.load_second) begin
      period <= COUNTER_WIDTH'(cap_in) - COUNTER_WIDTH'(first_cap);
      err    <= (cap_in == first_cap);
      dir    <= direction_level;
    end
    if (cmd.load_prod) begin
      divisor <= DW'(period) * DW'(pre_eff);
      rem     <= '0;
      quo     <= FREQ_W'({clock_hz, {Q8_SHIFT{1'b0}}});
    end
    if (cmd.div_step) begin
      rem <= ge ? FREQ_W'(diff) : FREQ_W'(trial);
      quo <= {quo[FREQ_W-2:0], ge};
    end
    if (cmd.load_out) begin
      period_ticks      <= err ? '0 : CAP_W'(period);
      frequency_q8      <= err ? '0 : quo;
      capture_error     <= err;
      direction_forward <= dir;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/cpfm_ctrl.sv
// Controller: capture sequencing, divider step count and output valid.
`default_nettype none

module cpfm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  input  wire cpfm_pkg::cpfm_sts_t sts,
  output cpfm_pkg::cpfm_cmd_t      cmd
);
  import cpfm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  state_t            state;
  logic              awaiting;
  logic [STEP_W-1:0] step;
  logic              in_acc;
  logic              out_free;

  always_comb begin
    in_stall        = (state != S_IDLE);
    in_acc          = in_valid && !in_stall;
    out_free        = !out_valid || !out_stall;
    cmd.load_first  = in_acc && !awaiting;
    cmd.load_second = in_acc && awaiting;
    cmd.load_prod   = (state == S_MUL);
    cmd.div_step    = (state == S_DIV);
    cmd.load_out    = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      awaiting  <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            awaiting <= !awaiting;
            if (awaiting) begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          step  <= '0;
          state <= sts.err ? S_DONE : S_DIV;
        end
        S_DIV: begin
          step <= step + STEP_W'(1);
          if (step == LAST_STEP) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/capture_period_frequency_meter.sv
// Top level of the capture period and reciprocal frequency meter.
// Items are captures of a free-running COUNTER_WIDTH-bit counter with the direction pin level.
// Captures pair up: the first of a pair is stored and gives no result, the second gives one
// result with the wrapped period, the frequency timer_clock_hz*256/(period*prescale_divisor)
// truncated in unsigned Q.8, and the direction level. Equal captures flag capture_error with
// period and frequency 0. A first capture is stored when it is accepted. The result of a second
// capture passes these steps: the accepting edge latches the period, the multiply state
// registers period times prescaler and seeds the divider, the bit-serial restoring divider
// gives one quotient bit per cycle, and the done state loads the output register once it is
// free; an error skips the divider. in_stall stays high from the accept until the result
// is loaded and while a finished result waits on a stalled output register. Configuration
// writes are always ready and must only be issued while the block is idle.
`default_nettype none

module capture_period_frequency_meter #(
  parameter int COUNTER_WIDTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration write channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [cpfm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cpfm_pkg::CFG_DATA_W-1:0]  cfg_data,
  // capture item channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [cpfm_pkg::CAP_W-1:0]       capture_value,
  input  wire logic                             direction_level,
  // result item channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [cpfm_pkg::CAP_W-1:0]            period_ticks,
  output logic [cpfm_pkg::FREQ_W-1:0]           frequency_q8,
  output logic                                  capture_error,
  output logic                                  direction_forward
);
  import cpfm_pkg::*;

  cpfm_cmd_t cmd;
  cpfm_sts_t sts;
  logic      cfg_we;

  // registers are plain flops; a write is always accepted and stored directly
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  cpfm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  cpfm_dp #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .capture_value     (capture_value),
    .direction_level   (direction_level),
    .cmd               (cmd),
    .sts               (sts),
    .period_ticks      (period_ticks),
    .frequency_q8      (frequency_q8),
    .capture_error     (capture_error),
    .direction_forward (direction_forward)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/cpfm_checker.sv
// Port-level checks for the frequency meter, bound to the top level.
`default_nettype none

module cpfm_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_stall,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic [cpfm_pkg::CAP_W-1:0]       period_ticks,
  input wire logic [cpfm_pkg::FREQ_W-1:0]      frequency_q8,
  input wire logic                             capture_error
);

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");

  // a held result is not dropped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // error results carry zero period and frequency
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && capture_error |-> (period_ticks == '0) && (frequency_q8 == '0))
    else $error("error result with nonzero payload");

  // a good result never shows a zero period
  a_period_nz: assert property (@(posedge clk) disable iff (rst)
    out_valid && !capture_error |-> (period_ticks != '0))
    else $error("zero period without error");

  // a new result only appears after the block was busy computing
  a_busy_first: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without busy phase");

endmodule

bind capture_period_frequency_meter cpfm_checker u_cpfm_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .period_ticks  (period_ticks),
  .frequency_q8  (frequency_q8),
  .capture_error (capture_error)
);

`default_nettype wire
